// ===== rtl/frcs_pkg.sv =====
// ============================================================================
// Flash request chunk splitter package
// Shared item types, operation and status codes, and fixed sizes used by
// the splitter and its chunk sizing unit.
// ============================================================================
package frcs_pkg;

    // Field widths fixed by the item formats.
    localparam int ADDR_W       = 24;
    localparam int LEN_W        = 16;
    localparam int FSIZE_W      = 25;
    localparam int PLOG_W       = 4;
    localparam int CHUNK_LEN_W  = 7;
    localparam int BUF_OFF_W    = 10;
    localparam int CFG_INDEX_W  = 1;

    // Fixed sizes of the flash geometry.
    localparam int SECTOR_BYTES   = 4096;
    localparam int PAGE_LOG2_MIN  = 6;
    localparam int PAGE_LOG2_MAX  = 12;
    localparam int PAGE_REM_W     = PAGE_LOG2_MAX + 1;
    localparam int MAX_RESULTS    = 64;
    localparam int RESULT_CNT_W   = $clog2(MAX_RESULTS);

    // Defaults for the top level parameters.
    localparam int DEF_WRITE_CHUNK_BYTES = 64;
    localparam int DEF_READ_CHUNK_BYTES  = 60;
    localparam int DEF_MAX_REQUEST_BYTES = 1024;

    // Configuration register reset values.
    localparam logic [FSIZE_W-1:0] FLASH_SIZE_RESET = 25'd4194304;
    localparam logic [PLOG_W-1:0]  PAGE_LOG2_RESET  = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_SIZE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_LOG2  = 1'd1;

    // Request kinds.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_ERASE = 2'd2;

    // Command operations.
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_PROGRAM = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_ERASE   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_RANGE      = 3'd1;
    localparam logic [2:0] ST_MISALIGN   = 3'd2;
    localparam logic [2:0] ST_ZERO_READ  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    // One request item.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] flash_addr;
        logic [LEN_W-1:0]  length;
    } t_in_item;

    // One command descriptor.
    typedef struct packed {
        logic [1:0]             op;
        logic [ADDR_W-1:0]      chunk_addr;
        logic [CHUNK_LEN_W-1:0] chunk_len;
        logic [BUF_OFF_W-1:0]   buf_offset;
        logic [2:0]             status;
        logic                   last;
    } t_out_item;

endpackage

// ===== rtl/frcs_chunk_unit.sv =====
// ============================================================================
// Chunk sizing unit
// Sizes the next command of a running request: the smallest of the bytes
// left, the room left in the program page (writes only) and the chunk limit.
// ============================================================================
module frcs_chunk_unit #(
    parameter int WRITE_CHUNK_BYTES = frcs_pkg::DEF_WRITE_CHUNK_BYTES,
    parameter int READ_CHUNK_BYTES  = frcs_pkg::DEF_READ_CHUNK_BYTES,
    parameter int REM_W             = 11
) (
    input  logic                                i_is_write,
    input  logic [frcs_pkg::ADDR_W-1:0]         i_next_addr,
    input  logic [REM_W-1:0]                    i_bytes_rem,
    input  logic [frcs_pkg::PLOG_W-1:0]         i_page_log2,
    output logic [frcs_pkg::CHUNK_LEN_W-1:0]    o_chunk_len,
    output logic [REM_W-1:0]                    o_rem_after
);

    localparam int PW = frcs_pkg::PAGE_REM_W;

    logic [frcs_pkg::PLOG_W-1:0] lg;
    logic [PW-1:0]               page;
    logic [PW-1:0]               page_off;
    logic [PW-1:0]               page_rem;
    logic [PW-1:0]               limit;
    logic [PW-1:0]               rem_w;
    logic [PW-1:0]               n_sz;

    // Clamp the page size to the supported range.
    always_comb begin
        if (i_page_log2 < frcs_pkg::PLOG_W'(frcs_pkg::PAGE_LOG2_MIN)) begin
            lg = frcs_pkg::PLOG_W'(frcs_pkg::PAGE_LOG2_MIN);
        end else if (i_page_log2 > frcs_pkg::PLOG_W'(frcs_pkg::PAGE_LOG2_MAX)) begin
            lg = frcs_pkg::PLOG_W'(frcs_pkg::PAGE_LOG2_MAX);
        end else begin
            lg = i_page_log2;
        end
    end

    // Room left in the current program page.
    assign page     = PW'(1) << lg;
    assign page_off = i_next_addr[PW-1:0] & (page - PW'(1));
    assign page_rem = page - page_off;

    // Minimum of bytes left, page room and chunk limit.
    assign limit = i_is_write ? PW'(WRITE_CHUNK_BYTES) : PW'(READ_CHUNK_BYTES);
    assign rem_w = PW'(i_bytes_rem);

    always_comb begin
        n_sz = rem_w;
        if (i_is_write && (page_rem < n_sz)) begin
            n_sz = page_rem;
        end
        if (limit < n_sz) begin
            n_sz = limit;
        end
    end

    assign o_chunk_len = n_sz[frcs_pkg::CHUNK_LEN_W-1:0];
    assign o_rem_after = i_bytes_rem - REM_W'(n_sz);

endmodule

// ===== rtl/flash_request_chunk_splitter_unit.sv =====
// ============================================================================
// Flash request chunk splitter
// Turns one flash request (program, read or sector erase) into a run of
// command descriptors, cut at page boundaries (writes only) and chunk limits.
// ============================================================================
// Usage:
//   Requests enter on i_in_valid / o_in_stall with payload i_in_item; an item
//   is taken on a clock edge with valid high and stall low. Descriptors leave
//   on o_out_valid / i_out_stall with payload o_out_item; the final one of a
//   request has last set. Configuration writes (flash size, page size log2)
//   use i_cfg_valid / o_cfg_ready and are taken at any time; they should be
//   made only while no request is in flight.
// Sequence:
//   Each request passes through a range and alignment check state (S_CHECK).
//   A single result (erase, error or empty write) is registered from that
//   state, and the sequencer returns to idle to take the next request. A
//   data request goes on to S_EMIT and gives R descriptors, one per cycle
//   from the shared chunk sizing unit while the receiver does not stall;
//   the longest with the defaults is a 1024-byte read in 60-byte chunks.
// Reset and stalls:
//   Reset returns the sequencer to idle, drops o_out_valid and restores the
//   configuration defaults. While the receiver stalls, the held descriptor
//   stays put and the sequencer waits; no descriptor is lost or repeated.
// ============================================================================
module flash_request_chunk_splitter_unit #(
    parameter int WRITE_CHUNK_BYTES = frcs_pkg::DEF_WRITE_CHUNK_BYTES,
    parameter int READ_CHUNK_BYTES  = frcs_pkg::DEF_READ_CHUNK_BYTES,
    parameter int MAX_REQUEST_BYTES = frcs_pkg::DEF_MAX_REQUEST_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  frcs_pkg::t_in_item                  i_in_item,
    // Descriptor channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output frcs_pkg::t_out_item                 o_out_item,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [frcs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [frcs_pkg::FSIZE_W-1:0]        i_cfg_data
);

    localparam int REM_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int AW    = frcs_pkg::ADDR_W;
    localparam int FW    = frcs_pkg::FSIZE_W;
    localparam int CW    = frcs_pkg::RESULT_CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } t_state;

    // Registers
    t_state                             r_state,      n_state;
    logic [FW-1:0]                      r_flash_size, n_flash_size;
    logic [frcs_pkg::PLOG_W-1:0]        r_page_log2,  n_page_log2;
    frcs_pkg::t_in_item                 r_req,        n_req;
    logic [AW-1:0]                      r_next_addr,  n_next_addr;
    logic [REM_W-1:0]                   r_bytes_rem,  n_bytes_rem;
    logic [frcs_pkg::BUF_OFF_W-1:0]     r_buf_pos,    n_buf_pos;
    logic [CW-1:0]                      r_cnt,        n_cnt;
    logic                               r_out_valid,  n_out_valid;
    frcs_pkg::t_out_item                r_out,        n_out;

    // Check logic and chunk unit results
    logic [FW-1:0]                      len_end;
    logic [FW-1:0]                      sec_end;
    logic                               len_range_bad;
    logic                               sec_range_bad;
    logic                               too_long;
    logic                               misaligned;
    logic                               zero_len;
    logic                               out_free;
    logic                               is_write;
    logic [frcs_pkg::CHUNK_LEN_W-1:0]   chunk_len;
    logic [REM_W-1:0]                   rem_after;
    logic                               chunk_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign out_free = !r_out_valid || !i_out_stall;

    // Range, length and alignment checks on the held request.
    assign len_end       = FW'(r_req.flash_addr) + FW'(r_req.length);
    assign sec_end       = FW'(r_req.flash_addr) + FW'(frcs_pkg::SECTOR_BYTES);
    assign len_range_bad = len_end > r_flash_size;
    assign sec_range_bad = sec_end > r_flash_size;
    assign too_long      = r_req.length > frcs_pkg::LEN_W'(MAX_REQUEST_BYTES);
    assign zero_len      = (r_req.length == '0);
    assign misaligned    = (r_req.flash_addr & AW'(frcs_pkg::SECTOR_BYTES - 1)) != '0;

    // Shared chunk sizing unit, used once per descriptor.
    assign is_write = (r_req.req_type == frcs_pkg::REQ_WRITE);

    frcs_chunk_unit #(
        .WRITE_CHUNK_BYTES (WRITE_CHUNK_BYTES),
        .READ_CHUNK_BYTES  (READ_CHUNK_BYTES),
        .REM_W             (REM_W)
    ) u_chunk (
        .i_is_write  (is_write),
        .i_next_addr (r_next_addr),
        .i_bytes_rem (r_bytes_rem),
        .i_page_log2 (r_page_log2),
        .o_chunk_len (chunk_len),
        .o_rem_after (rem_after)
    );

    assign chunk_last = (rem_after == '0) || (r_cnt == CW'(frcs_pkg::MAX_RESULTS - 1));

    // Sequencer and datapath next values.
    always_comb begin
        n_state      = r_state;
        n_flash_size = r_flash_size;
        n_page_log2  = r_page_log2;
        n_req        = r_req;
        n_next_addr  = r_next_addr;
        n_bytes_rem  = r_bytes_rem;
        n_buf_pos    = r_buf_pos;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        // The receiver takes the held descriptor.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Configuration writes.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                frcs_pkg::CFG_FLASH_SIZE: n_flash_size = i_cfg_data;
                frcs_pkg::CFG_PAGE_LOG2:  n_page_log2  = i_cfg_data[frcs_pkg::PLOG_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_item;
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                if (out_free) begin
                    // Default is a single closing result with no command.
                    n_out.op         = frcs_pkg::OP_NONE;
                    n_out.chunk_addr = r_req.flash_addr;
                    n_out.chunk_len  = '0;
                    n_out.buf_offset = '0;
                    n_out.status     = frcs_pkg::ST_OK;
                    n_out.last       = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                    n_next_addr      = r_req.flash_addr;
                    n_bytes_rem      = r_req.length[REM_W-1:0];
                    n_buf_pos        = '0;
                    n_cnt            = '0;
                    case (r_req.req_type)
                        frcs_pkg::REQ_ERASE: begin
                            if (sec_range_bad) begin
                                n_out.status = frcs_pkg::ST_RANGE;
                            end else if (misaligned) begin
                                n_out.status = frcs_pkg::ST_MISALIGN;
                            end else begin
                                n_out.op = frcs_pkg::OP_ERASE;
                            end
                        end
                        frcs_pkg::REQ_READ: begin
                            if (zero_len) begin
                                n_out.status = frcs_pkg::ST_ZERO_READ;
                            end else if (too_long) begin
                                n_out.status = frcs_pkg::ST_TOO_LONG;
                            end else if (len_range_bad) begin
                                n_out.status = frcs_pkg::ST_RANGE;
                            end else begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_state     = S_EMIT;
                            end
                        end
                        frcs_pkg::REQ_WRITE: begin
                            if (too_long) begin
                                n_out.status = frcs_pkg::ST_TOO_LONG;
                            end else if (len_range_bad) begin
                                n_out.status = frcs_pkg::ST_RANGE;
                            end else if (!zero_len) begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_state     = S_EMIT;
                            end
                        end
                        default: begin
                            n_out.status = frcs_pkg::ST_RANGE;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                // One descriptor per cycle while the output register is free.
                if (out_free) begin
                    n_out.op         = is_write ? frcs_pkg::OP_PROGRAM : frcs_pkg::OP_READ;
                    n_out.chunk_addr = r_next_addr;
                    n_out.chunk_len  = chunk_len;
                    n_out.buf_offset = r_buf_pos;
                    n_out.status     = frcs_pkg::ST_OK;
                    n_out.last       = chunk_last;
                    n_out_valid      = 1'b1;
                    n_next_addr      = r_next_addr + AW'(chunk_len);
                    n_buf_pos        = r_buf_pos + frcs_pkg::BUF_OFF_W'(chunk_len);
                    n_bytes_rem      = rem_after;
                    n_cnt            = r_cnt + CW'(1);
                    if (chunk_last) begin
                        n_bytes_rem = '0;
                        n_state     = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_flash_size <= frcs_pkg::FLASH_SIZE_RESET;
            r_page_log2  <= frcs_pkg::PAGE_LOG2_RESET;
            r_bytes_rem  <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_flash_size <= n_flash_size;
            r_page_log2  <= n_page_log2;
            r_bytes_rem  <= n_bytes_rem;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_next_addr <= n_next_addr;
        r_buf_pos   <= n_buf_pos;
        r_out       <= n_out;
    end

    // A result without a command always closes its request.
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.op == frcs_pkg::OP_NONE)) |-> r_out.last)
        else $error("result without a command is not marked last");

    // A result that is not the last one means the sequencer is still emitting.
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_state == S_EMIT))
        else $error("non-final result while sequencer is not emitting");

    // Data commands move between one byte and the default write chunk limit.
    a_chunk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.op == frcs_pkg::OP_PROGRAM || r_out.op == frcs_pkg::OP_READ))
        |-> (r_out.chunk_len != '0 &&
             r_out.chunk_len <= frcs_pkg::CHUNK_LEN_W'(frcs_pkg::DEF_WRITE_CHUNK_BYTES)))
        else $error("data command length out of bounds");

    // While emitting, bytes are always left to send.
    a_emit_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_bytes_rem != '0))
        else $error("emitting with no bytes remaining");

    // A stalled descriptor stays in place while the sequencer works.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("held descriptor changed under stall");

endmodule

// ===== sim/flash_request_chunk_splitter_unit_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Flash request chunk splitter checker
// Watches the request, descriptor and configuration channels of the splitter.
// Every accepted request is expanded into the descriptors it must produce.
// Every accepted descriptor is compared field by field with the oldest one
// still outstanding, and mismatches are counted for the testbench top.
// ============================================================================
module flash_request_chunk_splitter_unit_checker #(
    parameter int WRITE_CHUNK_BYTES = frcs_pkg::DEF_WRITE_CHUNK_BYTES,
    parameter int READ_CHUNK_BYTES  = frcs_pkg::DEF_READ_CHUNK_BYTES,
    parameter int MAX_REQUEST_BYTES = frcs_pkg::DEF_MAX_REQUEST_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  frcs_pkg::t_in_item                  i_in_item,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  frcs_pkg::t_out_item                 i_out_item,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [frcs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [frcs_pkg::FSIZE_W-1:0]        i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_pending,
    output int                                  o_descriptors_checked
);

    logic [frcs_pkg::FSIZE_W-1:0] flash_size_q = frcs_pkg::FLASH_SIZE_RESET;
    logic [frcs_pkg::PLOG_W-1:0]  page_log2_q  = frcs_pkg::PAGE_LOG2_RESET;
    frcs_pkg::t_out_item          expected_descriptors[$];
    int                           mismatch_count = 0;
    int                           checked_count  = 0;

    // Print one line per mismatch and count it.
    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            log_mismatch($sformatf("descriptor %0d: %s is 0x%0h, expected 0x%0h",
                                   checked_count, name, got, want));
        end
    endtask

    // A rejected or trivial request gives one descriptor with no command.
    function automatic frcs_pkg::t_out_item single_descriptor(
        input logic [1:0]                  op,
        input logic [frcs_pkg::ADDR_W-1:0] addr,
        input logic [2:0]                  status);
        frcs_pkg::t_out_item d;
        d.op         = op;
        d.chunk_addr = addr;
        d.chunk_len  = '0;
        d.buf_offset = '0;
        d.status     = status;
        d.last       = 1'b1;
        return d;
    endfunction

    // Expand one request into the descriptors the splitter must emit.
    task automatic predict_descriptors(input frcs_pkg::t_in_item req);
        int unsigned                    base;
        int unsigned                    size;
        int unsigned                    lg;
        int unsigned                    page;
        int unsigned                    remaining;
        int unsigned                    chunk;
        int unsigned                    page_left;
        int                             count;
        logic [frcs_pkg::ADDR_W-1:0]    cursor;
        logic [frcs_pkg::BUF_OFF_W-1:0] offset;
        frcs_pkg::t_out_item            d;
        bit                             accepted;

        base = req.flash_addr;
        size = flash_size_q;
        lg   = page_log2_q;
        if (lg < frcs_pkg::PAGE_LOG2_MIN) lg = frcs_pkg::PAGE_LOG2_MIN;
        if (lg > frcs_pkg::PAGE_LOG2_MAX) lg = frcs_pkg::PAGE_LOG2_MAX;
        page     = 1 << lg;
        accepted = 1'b0;

        // Checks in the order the splitter applies them per request kind.
        case (req.req_type)
            frcs_pkg::REQ_ERASE: begin
                if (base + frcs_pkg::SECTOR_BYTES > size) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_RANGE));
                end else if (req.flash_addr[11:0] != '0) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_MISALIGN));
                end else begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_ERASE, req.flash_addr, frcs_pkg::ST_OK));
                end
            end
            frcs_pkg::REQ_READ: begin
                if (req.length == '0) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_ZERO_READ));
                end else if (req.length > MAX_REQUEST_BYTES) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_TOO_LONG));
                end else if (base + req.length > size) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_RANGE));
                end else begin
                    accepted = 1'b1;
                end
            end
            frcs_pkg::REQ_WRITE: begin
                if (req.length > MAX_REQUEST_BYTES) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_TOO_LONG));
                end else if (base + req.length > size) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_RANGE));
                end else if (req.length == '0) begin
                    expected_descriptors.push_back(single_descriptor(
                        frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_OK));
                end else begin
                    accepted = 1'b1;
                end
            end
            default: begin
                // The unused request kind is reported as out of range.
                expected_descriptors.push_back(single_descriptor(
                    frcs_pkg::OP_NONE, req.flash_addr, frcs_pkg::ST_RANGE));
            end
        endcase

        if (accepted) begin
            remaining = req.length;
            cursor    = req.flash_addr;
            offset    = '0;
            count     = 0;
            // Writes stop at the page end and the chunk limit; reads at the chunk limit.
            while (remaining > 0 && count < frcs_pkg::MAX_RESULTS) begin
                chunk = remaining;
                if (req.req_type == frcs_pkg::REQ_WRITE) begin
                    page_left = page - (cursor & (page - 1));
                    if (chunk > page_left) chunk = page_left;
                    if (chunk > WRITE_CHUNK_BYTES) chunk = WRITE_CHUNK_BYTES;
                end else if (chunk > READ_CHUNK_BYTES) begin
                    chunk = READ_CHUNK_BYTES;
                end
                remaining    -= chunk;
                d.op         = (req.req_type == frcs_pkg::REQ_WRITE) ?
                               frcs_pkg::OP_PROGRAM : frcs_pkg::OP_READ;
                d.chunk_addr = cursor;
                d.chunk_len  = frcs_pkg::CHUNK_LEN_W'(chunk);
                d.buf_offset = offset;
                d.status     = frcs_pkg::ST_OK;
                d.last       = (remaining == 0) || (count == frcs_pkg::MAX_RESULTS - 1);
                expected_descriptors.push_back(d);
                count++;
                cursor = cursor + frcs_pkg::ADDR_W'(chunk);
                offset = offset + frcs_pkg::BUF_OFF_W'(chunk);
            end
        end
    endtask

    // Compare one accepted descriptor with the oldest outstanding one.
    task automatic check_descriptor(input frcs_pkg::t_out_item got);
        frcs_pkg::t_out_item want;

        if (expected_descriptors.size() == 0) begin
            log_mismatch($sformatf("descriptor with nothing outstanding: op %0d addr 0x%06h",
                                   got.op, got.chunk_addr));
        end else begin
            want = expected_descriptors.pop_front();
            check_field("op", got.op, want.op);
            check_field("chunk_addr", got.chunk_addr, want.chunk_addr);
            check_field("chunk_len", got.chunk_len, want.chunk_len);
            check_field("buf_offset", got.buf_offset, want.buf_offset);
            check_field("status", got.status, want.status);
            check_field("last", got.last, want.last);
            checked_count++;
        end
    endtask

    // Channel monitor; counters go out with nonblocking updates.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flash_size_q = frcs_pkg::FLASH_SIZE_RESET;
            page_log2_q  = frcs_pkg::PAGE_LOG2_RESET;
            expected_descriptors.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == frcs_pkg::CFG_FLASH_SIZE) begin
                    flash_size_q = i_cfg_data;
                end else if (i_cfg_index == frcs_pkg::CFG_PAGE_LOG2) begin
                    page_log2_q = i_cfg_data[frcs_pkg::PLOG_W-1:0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                check_descriptor(i_out_item);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_descriptors(i_in_item);
            end
        end
        o_pending             <= expected_descriptors.size();
        o_mismatches          <= mismatch_count;
        o_descriptors_checked <= checked_count;
    end

endmodule

// ===== sim/tb_flash_request_chunk_splitter_unit.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Flash request chunk splitter testbench
// Drives requests and configuration writes into the splitter with random
// idle and stall cycles, a long receiver hold-off and a full drain pause.
// A directed set covers the field extremes and every rejection path, then
// random phases run under several flash and page size settings.
// ============================================================================
module tb_flash_request_chunk_splitter_unit;

    // The one request kind the splitter does not define.
    localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
    localparam int         HOLDOFF_CYCLES  = 300;
    localparam int         IDLE_PERCENT    = 9;
    localparam int         PHASE_ITEMS     = 23;
    localparam int         SETTLE_CYCLES   = 40;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             req_valid   = 1'b0;
    logic                             req_stall;
    frcs_pkg::t_in_item               req_item    = '0;
    logic                             desc_valid;
    logic                             desc_stall  = 1'b0;
    frcs_pkg::t_out_item              desc_item;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [frcs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [frcs_pkg::FSIZE_W-1:0]     cfg_data  = '0;

    int mismatches;
    int pending;
    int descriptors_checked;

    logic [frcs_pkg::FSIZE_W-1:0] cur_flash_size = frcs_pkg::FLASH_SIZE_RESET;
    int  requests_sent    = 0;
    int  register_writes  = 0;
    bit  quiet            = 1'b0;
    int  holdoff_req      = 0;
    int  holdoff_seen     = 0;
    int  holdoff_left     = 0;

    always #2 clk = ~clk;

    flash_request_chunk_splitter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_item   (req_item),
        .o_out_valid (desc_valid),
        .i_out_stall (desc_stall),
        .o_out_item  (desc_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    flash_request_chunk_splitter_unit_checker checker_inst (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (req_valid),
        .i_in_stall            (req_stall),
        .i_in_item             (req_item),
        .i_out_valid           (desc_valid),
        .i_out_stall           (desc_stall),
        .i_out_item            (desc_item),
        .i_cfg_valid           (cfg_valid),
        .i_cfg_ready           (cfg_ready),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data),
        .o_mismatches          (mismatches),
        .o_pending             (pending),
        .o_descriptors_checked (descriptors_checked)
    );

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            desc_stall <= 1'b0;
        end else if (holdoff_left > 0) begin
            desc_stall   <= 1'b1;
            holdoff_left = holdoff_left - 1;
        end else if (holdoff_seen != holdoff_req) begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYCLES - 1;
            desc_stall   <= 1'b1;
        end else begin
            desc_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Offer one request, idling at random first, and wait until it is taken.
    task automatic send_request(input frcs_pkg::t_in_item req);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= req;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_fields(input logic [1:0] kind,
                               input logic [frcs_pkg::ADDR_W-1:0] addr,
                               input logic [frcs_pkg::LEN_W-1:0] len);
        frcs_pkg::t_in_item req;
        req.req_type   = kind;
        req.flash_addr = addr;
        req.length     = len;
        send_request(req);
    endtask

    // Stop offering and wait until every outstanding descriptor has come out.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_register(input logic [frcs_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [frcs_pkg::FSIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (index == frcs_pkg::CFG_FLASH_SIZE) cur_flash_size = value;
        register_writes++;
    endtask

    // Mostly well-formed requests that fit the flash, the rest raw noise.
    function automatic frcs_pkg::t_in_item random_request();
        frcs_pkg::t_in_item req;
        int unsigned        roll;
        int unsigned        len;
        int unsigned        fsize;

        fsize = cur_flash_size;
        roll  = $urandom_range(0, 99);
        if (roll < 40)      req.req_type = frcs_pkg::REQ_WRITE;
        else if (roll < 75) req.req_type = frcs_pkg::REQ_READ;
        else if (roll < 94) req.req_type = frcs_pkg::REQ_ERASE;
        else                req.req_type = REQ_UNKNOWN;
        req.flash_addr = frcs_pkg::ADDR_W'($urandom());
        req.length     = frcs_pkg::LEN_W'($urandom());
        if ($urandom_range(0, 99) < 85) begin
            if (req.req_type == frcs_pkg::REQ_ERASE) begin
                if (fsize >= frcs_pkg::SECTOR_BYTES) begin
                    req.flash_addr = frcs_pkg::ADDR_W'(
                        $urandom_range(0, fsize / frcs_pkg::SECTOR_BYTES - 1)
                        * frcs_pkg::SECTOR_BYTES);
                end
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 4)       len = 0;
                else if (roll < 70) len = $urandom_range(1, 128);
                else if (roll < 90) len = $urandom_range(129, 400);
                else                len = $urandom_range(401, frcs_pkg::DEF_MAX_REQUEST_BYTES);
                req.length = frcs_pkg::LEN_W'(len);
                if (fsize >= len) begin
                    req.flash_addr = frcs_pkg::ADDR_W'($urandom_range(0, fsize - len));
                end
            end
        end
        return req;
    endfunction

    task automatic run_random_phase(input logic [frcs_pkg::FSIZE_W-1:0] fsize,
                                    input logic [frcs_pkg::PLOG_W-1:0] plog,
                                    input bit pause_midway);
        write_register(frcs_pkg::CFG_FLASH_SIZE, fsize);
        write_register(frcs_pkg::CFG_PAGE_LOG2, frcs_pkg::FSIZE_W'(plog));
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (pause_midway && i == PHASE_ITEMS / 2) wait_for_drain();
            send_request(random_request());
        end
        wait_for_drain();
    endtask

    // Stimulus sequence and verdict.
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full 16 MiB flash, 256-byte pages.
        write_register(frcs_pkg::CFG_FLASH_SIZE, 25'd16777216);
        write_register(frcs_pkg::CFG_PAGE_LOG2, 25'd8);
        send_fields(frcs_pkg::REQ_WRITE, 24'h000000, 16'd0);
        send_fields(frcs_pkg::REQ_WRITE, 24'h0000F0, 16'd300);
        send_fields(frcs_pkg::REQ_WRITE, 24'h000010, 16'd1024);
        send_fields(frcs_pkg::REQ_WRITE, 24'h000000, 16'd1025);
        send_fields(frcs_pkg::REQ_WRITE, 24'hABCDEF, 16'hFFFF);
        send_fields(frcs_pkg::REQ_WRITE, 24'hFFFFFF, 16'd1);
        send_fields(frcs_pkg::REQ_WRITE, 24'hFFFFFF, 16'd2);
        send_fields(frcs_pkg::REQ_WRITE, 24'hFFFFC0, 16'd64);
        send_fields(frcs_pkg::REQ_READ,  24'h123456, 16'd0);
        send_fields(frcs_pkg::REQ_READ,  24'hFFFFFF, 16'd0);
        send_fields(frcs_pkg::REQ_READ,  24'h000000, 16'd1024);
        send_fields(frcs_pkg::REQ_READ,  24'h000100, 16'd1025);
        send_fields(frcs_pkg::REQ_READ,  24'h00003C, 16'd60);
        send_fields(frcs_pkg::REQ_READ,  24'h00003C, 16'd61);
        send_fields(frcs_pkg::REQ_READ,  24'hFFFFFF, 16'd2);
        send_fields(frcs_pkg::REQ_ERASE, 24'h000000, 16'd0);
        send_fields(frcs_pkg::REQ_ERASE, 24'hFFF000, 16'hFFFF);
        send_fields(frcs_pkg::REQ_ERASE, 24'h001001, 16'd0);
        send_fields(frcs_pkg::REQ_ERASE, 24'hFFFFFF, 16'd0);
        send_fields(REQ_UNKNOWN, 24'h5A5A5A, 16'h1234);
        wait_for_drain();

        // Page size below the minimum is clamped to 64 bytes; 64 KiB flash.
        write_register(frcs_pkg::CFG_PAGE_LOG2, 25'd0);
        write_register(frcs_pkg::CFG_FLASH_SIZE, 25'h0010000);
        send_fields(frcs_pkg::REQ_WRITE, 24'h00003F, 16'd200);
        send_fields(frcs_pkg::REQ_READ,  24'h00FFC4, 16'd60);
        send_fields(frcs_pkg::REQ_ERASE, 24'h00F000, 16'd0);
        send_fields(frcs_pkg::REQ_ERASE, 24'h010000, 16'd0);
        wait_for_drain();

        // Page size above the maximum is clamped to 4 KiB; empty flash.
        write_register(frcs_pkg::CFG_PAGE_LOG2, 25'd15);
        write_register(frcs_pkg::CFG_FLASH_SIZE, 25'd0);
        send_fields(frcs_pkg::REQ_WRITE, 24'h000000, 16'd0);
        send_fields(frcs_pkg::REQ_WRITE, 24'h000FF0, 16'd0);
        send_fields(frcs_pkg::REQ_READ,  24'h000000, 16'd1);
        send_fields(frcs_pkg::REQ_ERASE, 24'h000000, 16'd0);
        wait_for_drain();

        // Random phases: one with no idling, one behind a long receiver
        // hold-off, one with a full drain halfway through.
        quiet = 1'b1;
        run_random_phase(frcs_pkg::FLASH_SIZE_RESET, frcs_pkg::PAGE_LOG2_RESET, 1'b0);
        quiet = 1'b0;
        holdoff_req = holdoff_req + 1;
        run_random_phase(25'd16777216, 4'd12, 1'b0);
        run_random_phase(25'h0020000, 4'd6, 1'b1);
        run_random_phase(frcs_pkg::FSIZE_W'($urandom_range(frcs_pkg::SECTOR_BYTES, 16777216)),
                         frcs_pkg::PLOG_W'($urandom_range(0, 15)), 1'b0);

        // Let any stray descriptor show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d requests, %0d descriptors and %0d register writes.",
                 requests_sent, descriptors_checked, register_writes);
        $display("Included every request kind, page clamping at both ends, empty and full flash.");
        if (mismatches == 0 && pending == 0) begin
            $display("flash_request_chunk_splitter_unit regression: pass");
        end else begin
            $display("flash_request_chunk_splitter_unit regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Timed out with %0d descriptors outstanding.", pending);
        $display("flash_request_chunk_splitter_unit regression: fail");
        $finish;
    end

endmodule
